@@ sv/fbc_pkg.sv @@
// Shared constants and types for the frustum box cull core.
// Used by the channel interfaces and the core; no dependencies.
package fbc_pkg;

    // Default signed coordinate width (Q12.4 at 16 bits)
    localparam int COORD_WIDTH_DEF = 16;

    // Plane coefficient format
    localparam int COEF_W  = 16;
    localparam int D_SHIFT = 14;   // aligns d (Q12.4) with products (Q.18)

    // Planes and result codes
    localparam int NUM_PLANES = 6;
    localparam int CULL_W     = 3;
    localparam logic [CULL_W-1:0] PLANE_NEAR   = 3'd0;
    localparam logic [CULL_W-1:0] PLANE_FAR    = 3'd1;
    localparam logic [CULL_W-1:0] PLANE_LEFT   = 3'd2;
    localparam logic [CULL_W-1:0] PLANE_RIGHT  = 3'd3;
    localparam logic [CULL_W-1:0] PLANE_TOP    = 3'd4;
    localparam logic [CULL_W-1:0] PLANE_BOTTOM = 3'd5;
    localparam logic [CULL_W-1:0] CULL_NONE    = 3'd6;

    // Configuration register map: register i at byte address 8*i
    localparam int APB_DATA_W = 64;
    localparam int PADDR_W    = 6;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PLANE_FAR    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PLANE_TOP    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FAR_EN       = 3'd6;

    // One plane register: a in the low field, d in the high field
    typedef struct packed {
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] a;
    } plane_t;

endpackage

@@ sv/fbc_if.sv @@
// Valid/ready channels of the frustum box cull core: box in, verdict out.
// Depends on fbc_pkg for widths.
interface fbc_box_if #(
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [COORD_WIDTH-2:0] half_x;
    logic        [COORD_WIDTH-2:0] half_y;
    logic        [COORD_WIDTH-2:0] half_z;
    logic                          box_empty;
    logic                          box_infinite;

    modport source (
        output valid, center_x, center_y, center_z, half_x, half_y, half_z,
               box_empty, box_infinite,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, half_x, half_y, half_z,
               box_empty, box_infinite,
        output ready
    );
endinterface

interface fbc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          visible;
    logic [fbc_pkg::CULL_W-1:0]    culled_by;

    modport source (output valid, visible, culled_by, input ready);
    modport sink   (input  valid, visible, culled_by, output ready);
endinterface

@@ sv/frustum_box_cull_core.sv @@
// Frustum box cull core: tests boxes against six configured planes.
// Depends on fbc_pkg and the channel interfaces in fbc_if.sv.
//
//  channel   direction  handshake      payload
//  box       in         valid/ready    center_x/y/z, half_x/y/z, box_empty, box_infinite
//  result    out        valid/ready    visible, culled_by
//  apb       in         psel/penable   plane_near..plane_bottom, far_plane_enabled
//
// One box per cycle while the result side takes verdicts; a box's verdict passes
// through four register stages: products, plane sums, per-plane compares, then
// the priority pick in the output register. Each stage loads when it is empty
// or the next one loads, so bubbles close up under a stall and nothing is
// dropped or repeated.
// Reset clears all valid bits, zeroes the planes and enables the far plane.
module frustum_box_cull_core #(
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fbc_pkg::PADDR_W-1:0]      paddr,
    input  logic [fbc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fbc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    fbc_box_if.sink                          box,
    fbc_result_if.source                     result
);

    localparam int CW = COORD_WIDTH;
    localparam int HW = COORD_WIDTH - 1;
    localparam int NP = fbc_pkg::NUM_PLANES;
    localparam int PW = fbc_pkg::COEF_W + CW;            // signed center product
    localparam int EW = fbc_pkg::COEF_W + HW;            // unsigned extent product
    localparam int DW = fbc_pkg::COEF_W + fbc_pkg::D_SHIFT;
    localparam int AW = ((PW > DW) ? PW : DW) + 3;       // dist + ext headroom

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    fbc_pkg::plane_t                  plane_reg [NP];
    logic                             far_en_reg;
    logic [fbc_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                             cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[fbc_pkg::PADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++)
            begin
                plane_reg[i] <= '0;
            end
            far_en_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            if (reg_idx == fbc_pkg::REG_FAR_EN)
            begin
                far_en_reg <= pwdata[0];
            end
            else if (reg_idx < fbc_pkg::REG_FAR_EN)
            begin
                plane_reg[reg_idx] <= pwdata;
            end
        end
    end

    // Return the addressed register
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx) inside
            fbc_pkg::REG_PLANE_NEAR,
            fbc_pkg::REG_PLANE_FAR,
            fbc_pkg::REG_PLANE_LEFT,
            fbc_pkg::REG_PLANE_RIGHT,
            fbc_pkg::REG_PLANE_TOP,
            fbc_pkg::REG_PLANE_BOTTOM: prdata = plane_reg[reg_idx];
            fbc_pkg::REG_FAR_EN:       prdata = {{(fbc_pkg::APB_DATA_W-1){1'b0}}, far_en_reg};
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_load, s2_load, s3_load, out_load;

    assign out_load  = !out_valid_reg || result.ready;
    assign s3_load   = !s3_valid_reg || out_load;
    assign s2_load   = !s2_valid_reg || s3_load;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign box.ready = s1_load;

    // Advance valid bits with their stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)  s1_valid_reg  <= box.valid;
            if (s2_load)  s2_valid_reg  <= s1_valid_reg;
            if (s3_load)  s3_valid_reg  <= s2_valid_reg;
            if (out_load) out_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: center and extent products for every plane
    // ------------------------------------------------------------------
    logic signed [PW-1:0] pdist_next [NP][3];
    logic        [EW-1:0] pext_next  [NP][3];
    logic signed [PW-1:0] pdist_reg  [NP][3];
    logic        [EW-1:0] pext_reg   [NP][3];
    logic                 s1_empty_reg, s1_inf_reg;

    always_comb
    begin
        logic signed [PW-1:0]             cen  [3];
        logic        [EW-1:0]             half [3];
        logic signed [fbc_pkg::COEF_W-1:0] coef [3];
        logic signed [PW-1:0]             coef_ext;
        logic        [fbc_pkg::COEF_W-1:0] coef_abs;
        cen[0]  = PW'(box.center_x);
        cen[1]  = PW'(box.center_y);
        cen[2]  = PW'(box.center_z);
        half[0] = EW'(box.half_x);
        half[1] = EW'(box.half_y);
        half[2] = EW'(box.half_z);
        for (int p = 0; p < NP; p++)
        begin
            coef[0] = plane_reg[p].a;
            coef[1] = plane_reg[p].b;
            coef[2] = plane_reg[p].c;
            for (int k = 0; k < 3; k++)
            begin
                coef_ext = PW'(coef[k]);
                // Magnitude of the most negative code still fits unsigned
                coef_abs = coef[k][fbc_pkg::COEF_W-1] ? fbc_pkg::COEF_W'(-coef[k])
                                                     : fbc_pkg::COEF_W'(coef[k]);
                pdist_next[p][k] = coef_ext * cen[k];
                pext_next[p][k]  = EW'(coef_abs) * half[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && box.valid)
        begin
            pdist_reg    <= pdist_next;
            pext_reg     <= pext_next;
            s1_empty_reg <= box.box_empty;
            s1_inf_reg   <= box.box_infinite;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: signed distance and projected extent per plane
    // ------------------------------------------------------------------
    logic signed [AW-1:0] dist_next [NP];
    logic signed [AW-1:0] ext_next  [NP];
    logic signed [AW-1:0] dist_reg  [NP];
    logic signed [AW-1:0] ext_reg   [NP];
    logic                 s2_empty_reg, s2_inf_reg;

    always_comb
    begin
        for (int p = 0; p < NP; p++)
        begin
            dist_next[p] = AW'(pdist_reg[p][0]) + AW'(pdist_reg[p][1])
                         + AW'(pdist_reg[p][2])
                         + (AW'(plane_reg[p].d) <<< fbc_pkg::D_SHIFT);
            ext_next[p]  = AW'(pext_reg[p][0]) + AW'(pext_reg[p][1])
                         + AW'(pext_reg[p][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            dist_reg     <= dist_next;
            ext_reg      <= ext_next;
            s2_empty_reg <= s1_empty_reg;
            s2_inf_reg   <= s1_inf_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: per-plane outside test, dist < -ext
    // ------------------------------------------------------------------
    logic [NP-1:0] cull_next;
    logic [NP-1:0] cull_reg;
    logic          s3_empty_reg, s3_inf_reg;

    always_comb
    begin
        logic signed [AW-1:0] margin;
        for (int p = 0; p < NP; p++)
        begin
            margin       = dist_reg[p] + ext_reg[p];
            cull_next[p] = margin[AW-1];
        end
        // Skip the far plane when it is disabled
        cull_next[fbc_pkg::PLANE_FAR] = cull_next[fbc_pkg::PLANE_FAR] & far_en_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_load && s2_valid_reg)
        begin
            cull_reg     <= cull_next;
            s3_empty_reg <= s2_empty_reg;
            s3_inf_reg   <= s2_inf_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: first culling plane, then empty/infinite override
    // ------------------------------------------------------------------
    logic                       visible_next, visible_reg;
    logic [fbc_pkg::CULL_W-1:0] culled_next, culled_reg;

    always_comb
    begin
        culled_next = fbc_pkg::CULL_NONE;
        for (int p = NP - 1; p >= 0; p--)
        begin
            if (cull_reg[p])
            begin
                culled_next = fbc_pkg::CULL_W'(p);
            end
        end
        visible_next = (culled_next == fbc_pkg::CULL_NONE);
        if (s3_empty_reg)
        begin
            visible_next = 1'b0;
            culled_next  = fbc_pkg::CULL_NONE;
        end
        else if (s3_inf_reg)
        begin
            visible_next = 1'b1;
            culled_next  = fbc_pkg::CULL_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s3_valid_reg)
        begin
            visible_reg <= visible_next;
            culled_reg  <= culled_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.visible   = visible_reg;
    assign result.culled_by = culled_reg;

`ifndef SYNTHESIS
    // An empty box leaves as invisible with no plane blamed
    a_empty_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && s3_valid_reg && s3_empty_reg) |=>
            (result.valid && !result.visible && result.culled_by == fbc_pkg::CULL_NONE))
        else $error("empty box verdict wrong");

    // A visible verdict never names a plane
    a_visible_code: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.visible) |-> (result.culled_by == fbc_pkg::CULL_NONE))
        else $error("visible box carries a culling plane");

    // The far plane is never blamed while it is disabled
    a_far_skipped: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !far_en_reg) |-> (result.culled_by != fbc_pkg::PLANE_FAR))
        else $error("disabled far plane reported");

    // A stalled output stage holds the stage behind it in place
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && s3_valid_reg) |=> s3_valid_reg)
        else $error("stage 3 item lost under stall");
`endif

endmodule

@@ tb/frustum_box_cull_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the frustum box cull core: watches the box, verdict and APB
// traffic, predicts each verdict from its own copy of the planes and compares.
// Depends on fbc_pkg and the channel interfaces in fbc_if.sv.
module frustum_box_cull_checker #(
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [fbc_pkg::PADDR_W-1:0]    paddr,
    input  logic [fbc_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [fbc_pkg::APB_DATA_W-1:0] prdata,
    fbc_box_if                             box,
    fbc_result_if                          result,
    output int                             fail_count,
    output int                             pending,
    output int                             verdicts_checked,
    output int                             culled_total,
    output logic [fbc_pkg::NUM_PLANES:0]   planes_blamed
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                       visible;
        logic [fbc_pkg::CULL_W-1:0] culled_by;
    } cull_verdict_t;

    fbc_pkg::plane_t plane_copy [fbc_pkg::NUM_PLANES];
    logic            far_enabled;
    cull_verdict_t   expected_verdicts [$];

    // Count a failure; print only the first few
    task automatic note_fault(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%0t: %s", $time, what);
        end
    endtask

    // Test one box against the planes in priority order; first failing plane wins
    function automatic cull_verdict_t predict_verdict(
        input logic signed [COORD_WIDTH-1:0] cx,
        input logic signed [COORD_WIDTH-1:0] cy,
        input logic signed [COORD_WIDTH-1:0] cz,
        input logic        [COORD_WIDTH-2:0] hx,
        input logic        [COORD_WIDTH-2:0] hy,
        input logic        [COORD_WIDTH-2:0] hz,
        input logic                          empty,
        input logic                          infinite
    );
        cull_verdict_t v;
        longint a, b, c, d, sdist, reach;
        longint cxl, cyl, czl, hxl, hyl, hzl;
        int p;
        v.visible   = 1'b1;
        v.culled_by = fbc_pkg::CULL_NONE;
        cxl = cx;
        cyl = cy;
        czl = cz;
        hxl = hx;
        hyl = hy;
        hzl = hz;
        if (empty)
        begin
            v.visible = 1'b0;
        end
        else if (!infinite)
        begin
            for (p = 0; p < fbc_pkg::NUM_PLANES; p++)
            begin
                if (v.visible && (p != int'(fbc_pkg::PLANE_FAR) || far_enabled))
                begin
                    a = plane_copy[p].a;
                    b = plane_copy[p].b;
                    c = plane_copy[p].c;
                    d = plane_copy[p].d;
                    // signed centre distance and largest extent, both in Q.18
                    sdist = a * cxl + b * cyl + c * czl
                          + d * (longint'(1) << fbc_pkg::D_SHIFT);
                    reach = ((a < 0) ? -a : a) * hxl + ((b < 0) ? -b : b) * hyl
                          + ((c < 0) ? -c : c) * hzl;
                    if (sdist < -reach)
                    begin
                        v.visible   = 1'b0;
                        v.culled_by = fbc_pkg::CULL_W'(p);
                    end
                end
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cull_verdict_t got, want;
        int idx;
        if (!rst_n)
        begin
            for (idx = 0; idx < fbc_pkg::NUM_PLANES; idx++)
            begin
                plane_copy[idx] = '0;
            end
            far_enabled = 1'b1;
            expected_verdicts.delete();
            fail_count       = 0;
            pending          = 0;
            verdicts_checked = 0;
            culled_total     = 0;
            planes_blamed    = '0;
        end
        else
        begin
            idx = int'(paddr >> 3);

            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                if (idx < fbc_pkg::NUM_PLANES)
                    plane_copy[idx] = pwdata;
                else if (idx == int'(fbc_pkg::REG_FAR_EN))
                    far_enabled = pwdata[0];
            end

            // Check read data against the shadow copy
            if (psel && penable && !pwrite && pready)
            begin
                if (idx < fbc_pkg::NUM_PLANES && prdata !== plane_copy[idx])
                    note_fault($sformatf("register %0d read: expected %h, got %h",
                                         idx, plane_copy[idx], prdata));
                else if (idx == int'(fbc_pkg::REG_FAR_EN) && prdata[0] !== far_enabled)
                    note_fault($sformatf("far enable read: expected %b, got %b",
                                         far_enabled, prdata[0]));
            end

            // Predict the verdict of every box transfer
            if (box.valid && box.ready)
            begin
                expected_verdicts.push_back(predict_verdict(
                    box.center_x, box.center_y, box.center_z,
                    box.half_x, box.half_y, box.half_z,
                    box.box_empty, box.box_infinite));
            end

            // Compare every verdict transfer with the oldest prediction
            if (result.valid && result.ready)
            begin
                got.visible   = result.visible;
                got.culled_by = result.culled_by;
                if (expected_verdicts.size() == 0)
                begin
                    note_fault($sformatf("verdict with no box pending: visible=%b culled_by=%0d",
                                         got.visible, got.culled_by));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    verdicts_checked++;
                    if (got.visible !== want.visible || got.culled_by !== want.culled_by)
                        note_fault($sformatf(
                            "verdict %0d: expected visible/culled_by %b/%0d, got %b/%0d",
                            verdicts_checked, want.visible, want.culled_by,
                            got.visible, got.culled_by));
                    if (want.culled_by != fbc_pkg::CULL_NONE)
                        culled_total++;
                    planes_blamed[want.culled_by] = 1'b1;
                end
            end
            pending = expected_verdicts.size();
        end
    end

endmodule

@@ tb/frustum_box_cull_core_tb.sv @@
`timescale 1ns / 100ps
// Top of the frustum box cull testbench: clock, reset, APB set-up, box stimulus
// and verdict back-pressure. Depends on fbc_pkg, fbc_if.sv, the core and the checker.
module frustum_box_cull_core_tb;

    localparam int CW                = fbc_pkg::COORD_WIDTH_DEF;
    localparam int CLK_PERIOD        = 10;
    localparam int RESET_CYCLES      = 5;
    localparam int MAX_IDLE          = 17;
    localparam int RANDOM_PHASES     = 9;
    localparam int BOXES_PER_PHASE   = 150;
    localparam int FIRST_HOLD_AT     = 300;
    localparam int SECOND_HOLD_AT    = 900;
    localparam int LONG_HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES      = 20;
    localparam int TIMEOUT_NS        = 3_000_000;

    // Q1.14 and Q12.4 landmarks
    localparam int ONE_Q14    = 16384;
    localparam int DIAG_Q14   = 11585;
    localparam int ONE_Q4     = 16;
    localparam int COEF_MIN   = -32768;
    localparam int COEF_MAX   = 32767;
    localparam int HALF_MAX   = 32767;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
        logic        [CW-2:0] hx;
        logic        [CW-2:0] hy;
        logic        [CW-2:0] hz;
        logic                 empty;
        logic                 infinite;
    } box_item_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [fbc_pkg::PADDR_W-1:0]    paddr;
    logic [fbc_pkg::APB_DATA_W-1:0] pwdata;
    logic [fbc_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    int                             fail_count;
    int                             pending;
    int                             verdicts_checked;
    int                             culled_total;
    logic [fbc_pkg::NUM_PLANES:0]   planes_blamed;

    fbc_pkg::plane_t                phase_planes [fbc_pkg::NUM_PLANES];
    logic                           phase_far;
    int                             phases_run;
    logic                           send_burst;

    fbc_box_if #(.COORD_WIDTH(CW)) box_ch ();
    fbc_result_if                  verdict_ch ();

    frustum_box_cull_core #(.COORD_WIDTH(CW)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .box     (box_ch),
        .result  (verdict_ch)
    );

    frustum_box_cull_checker #(.COORD_WIDTH(CW)) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .box              (box_ch),
        .result           (verdict_ch),
        .fail_count       (fail_count),
        .pending          (pending),
        .verdicts_checked (verdicts_checked),
        .culled_total     (culled_total),
        .planes_blamed    (planes_blamed)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop if the run hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    function automatic fbc_pkg::plane_t mk_plane(input int a, input int b, input int c,
                                                 input int d);
        fbc_pkg::plane_t p;
        p.a = fbc_pkg::COEF_W'(a);
        p.b = fbc_pkg::COEF_W'(b);
        p.c = fbc_pkg::COEF_W'(c);
        p.d = fbc_pkg::COEF_W'(d);
        return p;
    endfunction

    function automatic box_item_t mk_box(input int cx, input int cy, input int cz,
                                         input int hx, input int hy, input int hz,
                                         input logic empty, input logic infinite);
        box_item_t it;
        it.cx       = CW'(cx);
        it.cy       = CW'(cy);
        it.cz       = CW'(cz);
        it.hx       = (CW-1)'(hx);
        it.hy       = (CW-1)'(hy);
        it.hz       = (CW-1)'(hz);
        it.empty    = empty;
        it.infinite = infinite;
        return it;
    endfunction

    // Base value moved by up to +/- span
    function automatic int jitter(input int base, input int span);
        return base + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0:       return COEF_MIN;
            1:       return COEF_MAX;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    // Mostly boxes around a plausible view volume, some full-range, some flagged
    function automatic box_item_t draw_box();
        box_item_t it;
        int kind;
        kind        = $urandom_range(0, 15);
        it.cx       = CW'($urandom);
        it.cy       = CW'($urandom);
        it.cz       = CW'($urandom);
        it.hx       = (CW-1)'($urandom);
        it.hy       = (CW-1)'($urandom);
        it.hz       = (CW-1)'($urandom);
        it.empty    = 1'b0;
        it.infinite = 1'b0;
        if (kind == 0)
        begin
            it.empty    = 1'b1;
            it.infinite = 1'($urandom_range(0, 1));
        end
        else if (kind == 1)
        begin
            it.infinite = 1'b1;
        end
        else if (kind > 3)
        begin
            it.cx = CW'(int'($urandom_range(0, 4095)) - 2048);
            it.cy = CW'(int'($urandom_range(0, 4095)) - 2048);
            it.cz = CW'(int'($urandom_range(0, 3583)) - 512);
            if ($urandom_range(0, 3) == 0)
            begin
                it.hx = '0;
                it.hy = '0;
                it.hz = '0;
            end
            else if ($urandom_range(0, 15) != 0)
            begin
                it.hx = (CW-1)'($urandom_range(0, 255));
                it.hy = (CW-1)'($urandom_range(0, 255));
                it.hz = (CW-1)'($urandom_range(0, 255));
            end
        end
        return it;
    endfunction

    // Plane set for one random phase: frustum-like, fully random or extremes
    task automatic pick_planes(input int kind);
        int i;
        if (kind == 0)
        begin
            phase_planes[fbc_pkg::PLANE_NEAR] =
                mk_plane(jitter(0, 800), jitter(0, 800),
                         jitter(ONE_Q14, 2000), jitter(-ONE_Q4, 256));
            phase_planes[fbc_pkg::PLANE_FAR] =
                mk_plane(jitter(0, 800), jitter(0, 800),
                         jitter(-ONE_Q14, 2000), jitter(1600, 800));
            phase_planes[fbc_pkg::PLANE_LEFT] =
                mk_plane(jitter(DIAG_Q14, 2000), jitter(0, 800),
                         jitter(DIAG_Q14, 2000), jitter(0, 256));
            phase_planes[fbc_pkg::PLANE_RIGHT] =
                mk_plane(jitter(-DIAG_Q14, 2000), jitter(0, 800),
                         jitter(DIAG_Q14, 2000), jitter(0, 256));
            phase_planes[fbc_pkg::PLANE_TOP] =
                mk_plane(jitter(0, 800), jitter(-DIAG_Q14, 2000),
                         jitter(DIAG_Q14, 2000), jitter(0, 256));
            phase_planes[fbc_pkg::PLANE_BOTTOM] =
                mk_plane(jitter(0, 800), jitter(DIAG_Q14, 2000),
                         jitter(DIAG_Q14, 2000), jitter(0, 256));
        end
        else
        begin
            for (i = 0; i < fbc_pkg::NUM_PLANES; i++)
            begin
                if (kind == 1)
                    phase_planes[i] = {$urandom, $urandom};
                else
                    phase_planes[i] = mk_plane(pick_extreme(), pick_extreme(),
                                               pick_extreme(), pick_extreme());
            end
        end
        phase_far = 1'($urandom_range(0, 1));
    endtask

    // One APB access: setup cycle, then access cycle until pready
    task automatic apb_access(input logic wr, input logic [fbc_pkg::REG_IDX_W-1:0] idx,
                              input logic [fbc_pkg::APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= fbc_pkg::PADDR_W'({idx, 3'b000});
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic readback_settings();
        int i;
        for (i = 0; i < fbc_pkg::NUM_PLANES; i++)
        begin
            apb_access(1'b0, fbc_pkg::REG_PLANE_NEAR + fbc_pkg::REG_IDX_W'(i), '0);
        end
        apb_access(1'b0, fbc_pkg::REG_FAR_EN, '0);
    endtask

    task automatic load_settings();
        int i;
        for (i = 0; i < fbc_pkg::NUM_PLANES; i++)
        begin
            apb_access(1'b1, fbc_pkg::REG_PLANE_NEAR + fbc_pkg::REG_IDX_W'(i),
                       phase_planes[i]);
        end
        apb_access(1'b1, fbc_pkg::REG_FAR_EN, fbc_pkg::APB_DATA_W'(phase_far));
        readback_settings();
        phases_run++;
    endtask

    // Offer one box after a random gap and hold it until the transfer
    task automatic send_box(input box_item_t it);
        int gap;
        if ($urandom_range(0, 31) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge clk);
        if (gap > 0)
        begin
            box_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        box_ch.center_x     <= it.cx;
        box_ch.center_y     <= it.cy;
        box_ch.center_z     <= it.cz;
        box_ch.half_x       <= it.hx;
        box_ch.half_y       <= it.hy;
        box_ch.half_z       <= it.hz;
        box_ch.box_empty    <= it.empty;
        box_ch.box_infinite <= it.infinite;
        box_ch.valid        <= 1'b1;
        do @(posedge clk); while (!(box_ch.valid && box_ch.ready));
    endtask

    // Drop valid and wait until every verdict is back
    task automatic finish_phase();
        @(negedge clk);
        box_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Verdict side: random stalls, burst stretches and two long holds
    initial
    begin
        int   stall;
        int   taken;
        logic burst;
        verdict_ch.ready = 1'b0;
        taken = 0;
        burst = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 31) == 0)
                burst = !burst;
            stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (taken == FIRST_HOLD_AT || taken == SECOND_HOLD_AT)
                stall = LONG_HOLD_CYCLES;
            if (stall > 0)
            begin
                verdict_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            verdict_ch.ready <= 1'b1;
            do @(posedge clk); while (!(verdict_ch.valid && verdict_ch.ready));
            taken++;
        end
    end

    // Stimulus and verdict
    initial
    begin
        int ph;
        int n;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        box_ch.valid        = 1'b0;
        box_ch.center_x     = '0;
        box_ch.center_y     = '0;
        box_ch.center_z     = '0;
        box_ch.half_x       = '0;
        box_ch.half_y       = '0;
        box_ch.half_z       = '0;
        box_ch.box_empty    = 1'b0;
        box_ch.box_infinite = 1'b0;
        send_burst          = 1'b0;
        phases_run          = 0;
        rst_n               = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: zero planes cull nothing
        readback_settings();
        send_box(mk_box(COEF_MIN, COEF_MIN, COEF_MIN, HALF_MAX, HALF_MAX, HALF_MAX, 0, 0));
        send_box(mk_box(COEF_MAX, COEF_MAX, COEF_MAX, 0, 0, 0, 0, 0));
        finish_phase();

        // Simple view frustum looking down +z, far plane at z = 100
        phase_planes[fbc_pkg::PLANE_NEAR]   = mk_plane(0, 0, ONE_Q14, -ONE_Q4);
        phase_planes[fbc_pkg::PLANE_FAR]    = mk_plane(0, 0, -ONE_Q14, 100 * ONE_Q4);
        phase_planes[fbc_pkg::PLANE_LEFT]   = mk_plane(DIAG_Q14, 0, DIAG_Q14, 0);
        phase_planes[fbc_pkg::PLANE_RIGHT]  = mk_plane(-DIAG_Q14, 0, DIAG_Q14, 0);
        phase_planes[fbc_pkg::PLANE_TOP]    = mk_plane(0, -DIAG_Q14, DIAG_Q14, 0);
        phase_planes[fbc_pkg::PLANE_BOTTOM] = mk_plane(0, DIAG_Q14, DIAG_Q14, 0);
        phase_far = 1'b1;
        load_settings();
        send_box(mk_box(0, 0, 800, 16, 16, 16, 0, 0));       // inside
        send_box(mk_box(0, 0, -800, 16, 16, 16, 0, 0));      // behind near
        send_box(mk_box(0, 0, 3000, 0, 0, 0, 0, 0));         // point past far
        send_box(mk_box(-2000, 0, 800, 0, 0, 0, 0, 0));      // off left
        send_box(mk_box(2000, 0, 800, 0, 0, 0, 0, 0));       // off right
        send_box(mk_box(0, 2000, 800, 0, 0, 0, 0, 0));       // above top
        send_box(mk_box(0, -2000, 800, 0, 0, 0, 0, 0));      // below bottom
        send_box(mk_box(0, 0, 800, 16, 16, 16, 1, 0));       // empty
        send_box(mk_box(0, 0, -800, 0, 0, 0, 0, 1));         // infinite, behind near
        send_box(mk_box(0, 0, 800, 0, 0, 0, 1, 1));          // empty wins over infinite
        send_box(mk_box(0, 0, -100, 0, 0, 200, 0, 0));       // straddles near plane
        send_box(mk_box(0, 0, ONE_Q4, 0, 0, 0, 0, 0));       // point exactly on near
        send_box(mk_box(COEF_MIN, COEF_MIN, COEF_MIN, HALF_MAX, HALF_MAX, HALF_MAX, 0, 0));
        send_box(mk_box(COEF_MAX, COEF_MAX, COEF_MAX, 0, 0, 0, 0, 0));
        send_box(mk_box(COEF_MIN, COEF_MAX, 0, 0, HALF_MAX, 0, 0, 0));
        finish_phase();

        // Far plane off: the distant point survives
        phase_far = 1'b0;
        load_settings();
        send_box(mk_box(0, 0, 3000, 0, 0, 0, 0, 0));
        send_box(mk_box(0, 0, -800, 0, 0, 0, 0, 0));
        finish_phase();

        // Extreme coefficients, most negative then most positive
        for (n = 0; n < fbc_pkg::NUM_PLANES; n++)
        begin
            phase_planes[n] = mk_plane(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        end
        phase_far = 1'b1;
        load_settings();
        send_box(mk_box(COEF_MAX, COEF_MAX, COEF_MAX, 0, 0, 0, 0, 0));
        send_box(mk_box(COEF_MIN, COEF_MIN, COEF_MIN, HALF_MAX, HALF_MAX, HALF_MAX, 0, 0));
        finish_phase();
        for (n = 0; n < fbc_pkg::NUM_PLANES; n++)
        begin
            phase_planes[n] = mk_plane(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        end
        load_settings();
        send_box(mk_box(COEF_MIN, COEF_MIN, COEF_MIN, 0, 0, 0, 0, 0));
        send_box(mk_box(COEF_MAX, COEF_MAX, COEF_MAX, HALF_MAX, HALF_MAX, HALF_MAX, 0, 0));
        finish_phase();

        // Random phases, cycling through the three kinds of plane set
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            pick_planes(ph % 3);
            load_settings();
            for (n = 0; n < BOXES_PER_PHASE; n++)
            begin
                send_box(draw_box());
            end
            finish_phase();
        end

        // Let any stray verdict show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d box verdicts over %0d plane settings; %0d boxes culled by a plane.",
                 verdicts_checked, phases_run, culled_total);
        $display("Verdict codes seen (bit per code, none in the top bit): %b", planes_blamed);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/fbc_pkg.sv
sv/fbc_if.sv
sv/frustum_box_cull_core.sv
tb/frustum_box_cull_checker.sv
tb/frustum_box_cull_core_tb.sv
